@@ hdl/ddod_pkg.sv @@
// shared types and constants for the dense detector output decoder
`timescale 1ns / 1ps

package ddod_pkg;

  // feature and result widths
  localparam int unsigned FeatW      = 32;
  localparam int unsigned BoxSizeW   = 31;
  localparam int unsigned ScoreW     = 17;
  localparam int unsigned ClassW     = 10;
  localparam int unsigned IndexW     = 11;
  localparam int unsigned ErrW       = 2;
  localparam int unsigned CountW     = 11;
  localparam int unsigned OutDataW   = 160;

  // proposal layout and limits
  localparam logic [IndexW-1:0] BoxValues  = IndexW'(4);
  localparam logic [CountW-1:0] MaxClasses = CountW'(1024);
  localparam logic [FeatW-2:0]  ScoreOne   = 31'd65536;

  // apb register map
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    REG_NUM_CLASSES = 2'd0,
    REG_MULTI_LABEL = 2'd1,
    REG_MIN_SCORE   = 2'd2
  } reg_idx_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 2'd0,
    ERR_BOX_SIZE  = 2'd1,
    ERR_SCORE     = 2'd2
  } err_code_e;

  // configuration seen by the decode core
  typedef struct packed {
    logic [CountW-1:0] num_classes;
    logic              multi_label;
    logic [ScoreW-1:0] min_score;
  } cfg_t;

  // one result transaction
  typedef struct packed {
    logic [FeatW-1:0]    box_x;
    logic [FeatW-1:0]    box_y;
    logic [BoxSizeW-1:0] box_w;
    logic [BoxSizeW-1:0] box_h;
    logic [ScoreW-1:0]   det_score;
    logic [ClassW-1:0]   det_class;
    err_code_e           error_code;
  } res_t;

endpackage

@@ hdl/ddod_decode.sv @@
// per-element decode state and result selection for the detector output decoder
`timescale 1ns / 1ps

module ddod_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [ddod_pkg::FeatW-1:0]    feature_i,
  input  logic                          start_i,
  input  ddod_pkg::cfg_t                cfg_i,
  output logic                          emit_o,
  output ddod_pkg::res_t                res_o
);

  logic [ddod_pkg::IndexW-1:0] index_q, index_d;
  logic [ddod_pkg::FeatW-1:0]  box_q [4];
  logic [ddod_pkg::ScoreW-1:0] top_score_q, top_score_d;
  logic [ddod_pkg::ClassW-1:0] top_class_q, top_class_d;
  logic                        err_q, err_d;

  logic [ddod_pkg::CountW-1:0] n_eff;
  logic [ddod_pkg::IndexW-1:0] index_cur;
  logic                        err_cur;
  logic [ddod_pkg::IndexW-1:0] cls_idx;
  logic [ddod_pkg::IndexW-1:0] cls_next;
  logic                        last;
  logic                        score_ok;
  logic                        size_neg;
  logic [ddod_pkg::ScoreW-1:0] score;
  logic                        box_we;
  logic [1:0]                  box_sel;

  // effective class count, clamped to 1..max
  always_comb begin
    n_eff = cfg_i.num_classes;
    if (cfg_i.num_classes == '0) begin
      n_eff = ddod_pkg::CountW'(1);
    end else if (cfg_i.num_classes > ddod_pkg::MaxClasses) begin
      n_eff = ddod_pkg::MaxClasses;
    end
  end

  // element decode
  always_comb begin
    index_cur    = start_i ? '0 : index_q;
    err_cur      = start_i ? 1'b0 : err_q;
    cls_idx      = index_cur - ddod_pkg::BoxValues;
    cls_next     = cls_idx + ddod_pkg::IndexW'(1);
    last         = (cls_next >= n_eff);
    score        = feature_i[ddod_pkg::ScoreW-1:0];
    score_ok     = !feature_i[ddod_pkg::FeatW-1] &&
                   (feature_i[ddod_pkg::FeatW-2:0] <= ddod_pkg::ScoreOne);
    size_neg     = box_q[2][ddod_pkg::FeatW-1] || feature_i[ddod_pkg::FeatW-1];
    box_sel      = index_cur[1:0];
    box_we       = 1'b0;
    index_d      = index_cur;
    err_d        = err_cur;
    top_score_d  = top_score_q;
    top_class_d  = top_class_q;
    emit_o       = 1'b0;
    res_o.box_x      = box_q[0];
    res_o.box_y      = box_q[1];
    res_o.box_w      = box_q[2][ddod_pkg::BoxSizeW-1:0];
    res_o.box_h      = box_q[3][ddod_pkg::BoxSizeW-1:0];
    res_o.det_score  = score;
    res_o.det_class  = cls_idx[ddod_pkg::ClassW-1:0];
    res_o.error_code = ddod_pkg::ERR_NONE;

    if (step_i && !err_cur) begin
      if (index_cur < ddod_pkg::BoxValues) begin
        // box element
        box_we  = 1'b1;
        index_d = index_cur + ddod_pkg::IndexW'(1);
        if (box_sel == 2'd3 && size_neg) begin
          emit_o           = 1'b1;
          err_d            = 1'b1;
          index_d          = '0;
          res_o            = '0;
          res_o.error_code = ddod_pkg::ERR_BOX_SIZE;
        end
      end else if (!score_ok) begin
        // score outside zero..one
        emit_o           = 1'b1;
        err_d            = 1'b1;
        index_d          = '0;
        res_o            = '0;
        res_o.error_code = ddod_pkg::ERR_SCORE;
      end else begin
        index_d = last ? '0 : index_cur + ddod_pkg::IndexW'(1);
        if (cfg_i.multi_label) begin
          emit_o = (score >= cfg_i.min_score);
        end else begin
          // running argmax, first maximum wins
          if (cls_idx == '0 || score > top_score_q) begin
            top_score_d = score;
            top_class_d = cls_idx[ddod_pkg::ClassW-1:0];
          end
          emit_o          = last && (top_score_d >= cfg_i.min_score);
          res_o.det_score = top_score_d;
          res_o.det_class = top_class_d;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q     <= '0;
      err_q       <= 1'b0;
      top_score_q <= '0;
      top_class_q <= '0;
    end else if (step_i) begin
      index_q     <= index_d;
      err_q       <= err_d;
      top_score_q <= top_score_d;
      top_class_q <= top_class_d;
    end
  end

  // box store, written before read within a proposal
  always_ff @(posedge clk_i) begin
    if (box_we) begin
      box_q[box_sel] <= feature_i;
    end
  end

endmodule

@@ hdl/dense_detector_output_decode.sv @@
// top level of the dense detector output decoder: stream ports, apb registers, staging
// Takes one tensor element per cycle unless m_axis_tready stalls the output: each
// element passes an input register, decode against the per-proposal state, and a
// result register, which offers the result transaction on the output. Throughput is
// one element per cycle unless stalled, set by the state update of the decode core.
// Elements carry tensor_start in tuser; a box error or a score outside zero..one gives
// one error transaction and the block drops elements until the next tensor start. The user
// must write registers over apb only while the stream is idle; the block does not enforce it.
`timescale 1ns / 1ps

module dense_detector_output_decode (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ddod_pkg::FeatW-1:0]       s_axis_tdata,   // [31:0] feature_value
  input  logic                             s_axis_tuser,   // [0] tensor_start
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] box_x, [63:32] box_y, [94:64] box_w, [125:95] box_h,
  // [142:126] det_score, [152:143] det_class, [159:153] zero
  output logic [ddod_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic [ddod_pkg::ErrW-1:0]        m_axis_tuser,   // [1:0] error_code
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ddod_pkg::AddrW-1:0]       paddr,
  input  logic [ddod_pkg::DataW-1:0]       pwdata,
  output logic [ddod_pkg::DataW-1:0]       prdata,
  output logic                             pready
);

  ddod_pkg::cfg_t              cfg_q;
  ddod_pkg::reg_idx_e          reg_idx;
  logic                        cfg_we;

  logic                        in_valid_q;
  logic [ddod_pkg::FeatW-1:0]  in_data_q;
  logic                        in_start_q;
  logic                        out_valid_q;
  ddod_pkg::res_t              out_res_q;

  logic                        out_free;
  logic                        advance;
  logic                        emit;
  ddod_pkg::res_t              res;

  // apb register file
  assign pready  = 1'b1;
  assign reg_idx = ddod_pkg::reg_idx_e'(paddr[ddod_pkg::AddrW-1:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_classes <= ddod_pkg::CountW'(1);
      cfg_q.multi_label <= 1'b0;
      cfg_q.min_score   <= '0;
    end else if (cfg_we) begin
      case (reg_idx)
        ddod_pkg::REG_NUM_CLASSES: cfg_q.num_classes <= pwdata[ddod_pkg::CountW-1:0];
        ddod_pkg::REG_MULTI_LABEL: cfg_q.multi_label <= pwdata[0];
        ddod_pkg::REG_MIN_SCORE:   cfg_q.min_score   <= pwdata[ddod_pkg::ScoreW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    case (reg_idx)
      ddod_pkg::REG_NUM_CLASSES: prdata = ddod_pkg::DataW'(cfg_q.num_classes);
      ddod_pkg::REG_MULTI_LABEL: prdata = ddod_pkg::DataW'(cfg_q.multi_label);
      ddod_pkg::REG_MIN_SCORE:   prdata = ddod_pkg::DataW'(cfg_q.min_score);
      default:                   prdata = '0;
    endcase
  end

  // stage handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  ddod_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .feature_i (in_data_q),
    .start_i   (in_start_q),
    .cfg_i     (cfg_q),
    .emit_o    (emit),
    .res_o     (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_res_q <= res;
    end
  end

  // result transaction packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_res_q.det_class, out_res_q.det_score,
                          out_res_q.box_h, out_res_q.box_w,
                          out_res_q.box_y, out_res_q.box_x};
  assign m_axis_tuser  = out_res_q.error_code;

endmodule
